// ===== hdl/swwf_pkg.sv =====
// Package for the shallow water wall flux block: payload structs, fixed-point
// constants and the rounding and saturation helpers.
// No dependencies.
package swwf_pkg;

  localparam int FRAC  = 16;             // fraction bits of the Q format
  localparam int QB    = 33;             // quotient and root bits, one per stage
  localparam int NUM_W = 32 + FRAC + 1;  // divider numerator width
  localparam int GH_W  = 62;             // g*h product width
  localparam int SQ_W  = 2 * QB;         // sqrt radicand width, zero extended

  typedef struct packed {
    logic signed [31:0] depth;
    logic signed [31:0] mom_x;
    logic signed [31:0] mom_y;
    logic        [30:0] gravity;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
  } swwf_in_t;

  typedef struct packed {
    logic signed [31:0] flux_mass;
    logic signed [31:0] flux_mom_x;
    logic signed [31:0] flux_mom_y;
    logic        [30:0] jacobian_diag;
  } swwf_out_t;

  // v / 2^s, round to nearest, ties away from zero
  function automatic logic signed [63:0] rnd64(input logic signed [63:0] v,
                                               input int unsigned s);
    logic        neg;
    logic [63:0] m;
    neg = v[63];
    m   = neg ? (64'd0 - 64'(v)) : 64'(v);
    m   = (m + (64'd1 << (s - 1))) >> s;
    return neg ? $signed(64'd0 - m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return $signed(v[31:0]);
    end
  endfunction

endpackage

// ===== hdl/swwf_core.sv =====
// Datapath pipeline of the wall flux block: products, a 33-stage divider and
// square root running side by side, and the flux assembly.
// Depends on swwf_pkg. Every stage moves when en is high.
module swwf_core
  import swwf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_valid,
  input  swwf_in_t  in_data,
  input  logic [15:0] dry_thresh,
  output logic      res_valid,
  output swwf_out_t res_data
);

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [30:0]      den;
    logic [30:0]      rem;
    logic [QB-1:0]    q;
    logic             ovf;
    logic             neg;
  } div_t;

  typedef struct packed {
    logic [GH_W-1:0] x;
    logic [33:0]     rem;
    logic [QB-1:0]   root;
  } sq_t;

  typedef struct packed {
    logic signed [31:0] d1;
    logic signed [31:0] d2;
    logic        [30:0] p;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
  } side_t;

  // ---------------- stage A: clamp and dry test
  logic               a_v_r, a_wet_r;
  logic        [30:0] a_h_r, a_g_r;
  logic signed [31:0] a_hu_r, a_hv_r;
  logic signed [15:0] a_nx_r, a_ny_r;
  logic        [30:0] a_h_nxt;
  logic               a_wet_nxt;

  always_comb begin
    a_h_nxt   = in_data.depth[31] ? 31'd0 : in_data.depth[30:0];
    a_wet_nxt = a_h_nxt > 31'(dry_thresh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
    end
    if (en) begin
      a_h_r   <= a_h_nxt;
      a_wet_r <= a_wet_nxt;
      a_hu_r  <= a_wet_nxt ? in_data.mom_x : 32'sd0;
      a_hv_r  <= a_wet_nxt ? in_data.mom_y : 32'sd0;
      a_g_r   <= in_data.gravity;
      a_nx_r  <= in_data.normal_x;
      a_ny_r  <= in_data.normal_y;
    end
  end

  // ---------------- stage B: first products
  logic                  b_v_r, b_wet_r;
  logic           [30:0] b_h_r;
  logic signed    [31:0] b_hu_r, b_hv_r;
  logic signed    [15:0] b_nx_r, b_ny_r;
  logic signed    [47:0] b_hunx_r, b_hvny_r, b_hvnx_r, b_huny_r;
  logic       [GH_W-1:0] b_ghf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= a_v_r;
    end
    if (en) begin
      b_wet_r  <= a_wet_r;
      b_h_r    <= a_h_r;
      b_hu_r   <= a_hu_r;
      b_hv_r   <= a_hv_r;
      b_nx_r   <= a_nx_r;
      b_ny_r   <= a_ny_r;
      b_hunx_r <= a_hu_r * a_nx_r;
      b_hvny_r <= a_hv_r * a_ny_r;
      b_hvnx_r <= a_hv_r * a_nx_r;
      b_huny_r <= a_hu_r * a_ny_r;
      b_ghf_r  <= a_g_r * a_h_r;
    end
  end

  // ---------------- stage C: normal and tangential momentum, g*h
  logic                  c_v_r, c_wet_r;
  logic           [30:0] c_h_r, c_gh_r;
  logic signed    [31:0] c_hu_r, c_hv_r, c_qn_r, c_qt_r;
  logic signed    [15:0] c_nx_r, c_ny_r;
  logic       [GH_W-1:0] c_ghf_r;
  logic signed    [31:0] c_qn_nxt, c_qt_nxt;
  logic           [30:0] c_gh_nxt;

  always_comb begin
    logic signed [63:0] sn, st, rg;
    sn = 64'(b_hunx_r) + 64'(b_hvny_r);
    st = 64'(b_hvnx_r) - 64'(b_huny_r);
    rg = rnd64($signed({2'b00, b_ghf_r}), FRAC);
    c_qn_nxt = sat32(rnd64(sn, 14));
    c_qt_nxt = sat32(rnd64(st, 14));
    c_gh_nxt = (rg > 64'sd2147483647) ? 31'h7fffffff : rg[30:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en) begin
      c_v_r <= b_v_r;
    end
    if (en) begin
      c_wet_r <= b_wet_r;
      c_h_r   <= b_h_r;
      c_hu_r  <= b_hu_r;
      c_hv_r  <= b_hv_r;
      c_nx_r  <= b_nx_r;
      c_ny_r  <= b_ny_r;
      c_ghf_r <= b_ghf_r;
      c_qn_r  <= c_qn_nxt;
      c_qt_r  <= c_qt_nxt;
      c_gh_r  <= c_gh_nxt;
    end
  end

  // ---------------- stage D: mirror products, pressure product, divider setup
  logic                  d_v_r;
  logic signed    [31:0] d_hu_r, d_hv_r;
  logic signed    [15:0] d_nx_r, d_ny_r;
  logic signed    [47:0] d_qnnx_r, d_qtny_r, d_qtnx_r, d_qnny_r;
  logic       [GH_W-1:0] d_ghh_r, d_ghf_r;
  logic      [NUM_W-1:0] d_num_r;
  logic           [30:0] d_den_r;
  logic                  d_neg_r;
  logic      [NUM_W-1:0] d_num_nxt;
  logic           [30:0] d_den_nxt;

  always_comb begin
    logic [31:0] mag;
    mag       = c_qn_r[31] ? (32'd0 - 32'(c_qn_r)) : 32'(c_qn_r);
    // dry cells carry a zero numerator; a unit divisor keeps the divider sane
    d_den_nxt = c_wet_r ? c_h_r : 31'd1;
    d_num_nxt = (NUM_W'(mag) << FRAC) + NUM_W'(d_den_nxt >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (en) begin
      d_v_r <= c_v_r;
    end
    if (en) begin
      d_hu_r   <= c_hu_r;
      d_hv_r   <= c_hv_r;
      d_nx_r   <= c_nx_r;
      d_ny_r   <= c_ny_r;
      d_qnnx_r <= c_qn_r * c_nx_r;
      d_qtny_r <= c_qt_r * c_ny_r;
      d_qtnx_r <= c_qt_r * c_nx_r;
      d_qnny_r <= c_qn_r * c_ny_r;
      d_ghh_r  <= c_gh_r * c_h_r;
      d_ghf_r  <= c_ghf_r;
      d_num_r  <= d_num_nxt;
      d_den_r  <= d_den_nxt;
      d_neg_r  <= c_qn_r[31];
    end
  end

  // mirrored state, pressure and momentum jumps, carried beside the divider
  side_t side0;

  always_comb begin
    logic signed [63:0] sr, sv, rp;
    logic signed [31:0] hur, hvr;
    sr  = 64'sd0 - 64'(d_qnnx_r) - 64'(d_qtny_r);
    sv  = 64'(d_qtnx_r) - 64'(d_qnny_r);
    hur = sat32(rnd64(sr, 14));
    hvr = sat32(rnd64(sv, 14));
    rp  = rnd64($signed({2'b00, d_ghh_r}), FRAC + 1);
    side0.d1 = sat32(64'(d_hu_r) - 64'(hur));
    side0.d2 = sat32(64'(d_hv_r) - 64'(hvr));
    side0.p  = (rp > 64'sd2147483647) ? 31'h7fffffff : rp[30:0];
    side0.nx = d_nx_r;
    side0.ny = d_ny_r;
  end

  // ---------------- divider and square root, one result bit per stage
  logic  lp_v_r [QB];
  div_t  dv_r   [QB];
  sq_t   sq_r   [QB];
  side_t sd_r   [QB];

  for (genvar j = 0; j < QB; j++) begin : g_step
    div_t  dv_in, dv_nxt;
    sq_t   sq_in, sq_nxt;
    side_t sd_in;
    logic  v_in;

    if (j == 0) begin : g_first
      always_comb begin
        v_in         = d_v_r;
        dv_in.num    = d_num_r;
        dv_in.den    = d_den_r;
        dv_in.rem    = 31'(d_num_r >> QB);
        dv_in.q      = '0;
        // quotient of 2^QB or more saturates anyway
        dv_in.ovf    = (d_num_r >> QB) >= NUM_W'(d_den_r);
        dv_in.neg    = d_neg_r;
        sq_in.x      = d_ghf_r;
        sq_in.rem    = '0;
        sq_in.root   = '0;
        sd_in        = side0;
      end
    end else begin : g_next
      always_comb begin
        v_in  = lp_v_r[j-1];
        dv_in = dv_r[j-1];
        sq_in = sq_r[j-1];
        sd_in = sd_r[j-1];
      end
    end

    always_comb begin
      logic [31:0]     drem;
      logic            dge;
      logic [SQ_W-1:0] xx;
      logic [35:0]     srem, trial;
      logic            sge;
      drem   = {dv_in.rem, dv_in.num[QB-1-j]};
      dge    = drem >= {1'b0, dv_in.den};
      dv_nxt = dv_in;
      dv_nxt.rem = dge ? 31'(drem - {1'b0, dv_in.den}) : drem[30:0];
      dv_nxt.q   = {dv_in.q[QB-2:0], dge};
      xx     = SQ_W'(sq_in.x);
      srem   = {sq_in.rem, xx[SQ_W-1-2*j -: 2]};
      trial  = {1'b0, sq_in.root, 2'b01};
      sge    = srem >= trial;
      sq_nxt = sq_in;
      sq_nxt.rem  = sge ? 34'(srem - trial) : srem[33:0];
      sq_nxt.root = {sq_in.root[QB-2:0], sge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        lp_v_r[j] <= 1'b0;
      end else if (en) begin
        lp_v_r[j] <= v_in;
      end
      if (en) begin
        dv_r[j] <= dv_nxt;
        sq_r[j] <= sq_nxt;
        sd_r[j] <= sd_in;
      end
    end
  end

  // ---------------- stage F: velocity, wave speed, jump factor
  logic        f_v_r;
  logic [31:0] f_k_r;
  logic [30:0] f_jac_r;
  side_t       f_sd_r;
  logic [31:0] f_k_nxt;
  logic [30:0] f_jac_nxt;

  always_comb begin
    div_t               dl;
    logic [31:0]        ua;
    logic signed [31:0] un;
    logic [32:0]        smax;
    logic signed [33:0] ks;
    dl = dv_r[QB-1];
    if (dl.neg) begin
      ua = (dl.ovf || dl.q > 33'h080000000) ? 32'h80000000 : dl.q[31:0];
      un = $signed(32'd0 - ua);
    end else begin
      ua = (dl.ovf || dl.q > 33'h07fffffff) ? 32'h7fffffff : dl.q[31:0];
      un = $signed(ua);
    end
    smax      = {1'b0, ua} + {2'b00, sq_r[QB-1].root[30:0]};
    ks        = 34'(un) + $signed({1'b0, smax});
    f_k_nxt   = (ks[33:32] != 2'b00) ? 32'hffffffff : ks[31:0];
    f_jac_nxt = smax[32] ? 31'h7fffffff : smax[31:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (en) begin
      f_v_r <= lp_v_r[QB-1];
    end
    if (en) begin
      f_k_r   <= f_k_nxt;
      f_jac_r <= f_jac_nxt;
      f_sd_r  <= sd_r[QB-1];
    end
  end

  // ---------------- stage G: dissipation and pressure products
  logic               g_v_r;
  logic signed [63:0] g_dk1_r, g_dk2_r;
  logic signed [47:0] g_pn1_r, g_pn2_r;
  logic        [30:0] g_jac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_v_r <= 1'b0;
    end else if (en) begin
      g_v_r <= f_v_r;
    end
    if (en) begin
      g_dk1_r <= f_sd_r.d1 * $signed({1'b0, f_k_r});
      g_dk2_r <= f_sd_r.d2 * $signed({1'b0, f_k_r});
      g_pn1_r <= $signed({1'b0, f_sd_r.p}) * f_sd_r.nx;
      g_pn2_r <= $signed({1'b0, f_sd_r.p}) * f_sd_r.ny;
      g_jac_r <= f_jac_r;
    end
  end

  // ---------------- stage H: flux sums
  logic      h_v_r;
  swwf_out_t h_data_r;
  swwf_out_t h_data_nxt;

  always_comb begin
    logic signed [63:0] t1, t2;
    t1 = rnd64(g_dk1_r, FRAC + 1) + rnd64(64'(g_pn1_r), 14);
    t2 = rnd64(g_dk2_r, FRAC + 1) + rnd64(64'(g_pn2_r), 14);
    h_data_nxt.flux_mass     = 32'sd0;   // mirrored mass fluxes cancel
    h_data_nxt.flux_mom_x    = sat32(t1);
    h_data_nxt.flux_mom_y    = sat32(t2);
    h_data_nxt.jacobian_diag = g_jac_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_v_r <= 1'b0;
    end else if (en) begin
      h_v_r <= g_v_r;
    end
    if (en) begin
      h_data_r <= h_data_nxt;
    end
  end

  assign res_valid = h_v_r;
  assign res_data  = h_data_r;

endmodule

// ===== hdl/shallow_water_wall_flux_top.sv =====
// Top level of the shallow water wall flux block: dry threshold register,
// datapath pipeline and output register with skid stage.
// Depends on swwf_pkg and swwf_core.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   in_data  (swwf_in_t)
//   out      output     out_valid / out_stall out_data (swwf_out_t)
//   cfg      input      cfg_wr_en             cfg_wr_data (dry depth, 16 bit)
//
// One request per cycle while in_stall is low. 40 datapath register stages, 33
// of them the divider and square root, then the output register that drives
// out_valid.
// Reset (rst_n low, synchronous) empties the pipeline; dry depth resets to 1.
// A stalled output parks one result in the skid stage; the pipeline halts
// and in_stall rises only while the skid stage is full.
module shallow_water_wall_flux_top
  import swwf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  swwf_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output swwf_out_t   out_data,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic [15:0] dry_r;
  logic        en;
  logic        res_valid;
  swwf_out_t   res_data;
  logic        out_valid_r, skid_v_r;
  swwf_out_t   out_data_r, skid_data_r;
  logic        take, push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dry_r <= 16'd1;
    end else if (cfg_wr_en) begin
      dry_r <= cfg_wr_data;
    end
  end

  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  swwf_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .dry_thresh (dry_r),
    .res_valid  (res_valid),
    .res_data   (res_data)
  );

  assign take = out_valid_r && !out_stall;
  assign push = en && res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (!out_valid_r || take) begin
      out_valid_r <= skid_v_r || push;
      skid_v_r    <= 1'b0;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || take) begin
      out_data_r <= skid_v_r ? skid_data_r : res_data;
    end else if (push) begin
      skid_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // skid stage only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_valid_r)
    else $error("skid stage full with output register empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_valid_r && out_stall))
    else $error("skid stage filled without a stalled output");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && !out_stall) |=> !skid_v_r)
    else $error("skid stage did not drain after output was taken");

endmodule
